>>> design/pap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pap_pkg
// Shared constants and sequencer states for the polygon area/perimeter block.
// ----------------------------------------------------------------------------
package pap_pkg;

  localparam int MAX_CORNERS_DEF = 32;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = 17;
  localparam int PROD_W   = 34;
  localparam int SUM_W    = 40;
  localparam int AREA_W   = 38;
  localparam int PERIM_W  = 22;
  localparam int COUNT_W  = 6;
  localparam int ROOT_W   = 17;
  localparam int REM_W    = 18;
  localparam int SQ_W     = 34;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 72;

  localparam logic [COUNT_W-1:0] COUNT_CAP = 6'd63;
  localparam logic [AREA_W-1:0]  AREA_CAP  = 38'h20_0000_0000;
  localparam logic [PERIM_W-1:0] PERIM_CAP = 22'h3F_FFFF;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CLOSE   = 9'b000000010,
    S_MUL_A   = 9'b000000100,
    S_MUL_X   = 9'b000001000,
    S_MUL_Y   = 9'b000010000,
    S_ROOT_LD = 9'b000100000,
    S_ROOT    = 9'b001000000,
    S_ACC     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

endpackage
`default_nettype wire

>>> design/polygon_area_perimeter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_area_perimeter
// Shoelace twice-area and floored-root perimeter of a streamed polygon.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_*       in   tdata: x_coord[15:0], y_coord[31:16]; tlast: last_corner
// m_*       out  tdata: area[37:0], perimeter[59:38], corner_count[65:60];
//                tuser: too_many
//
// Each corner after the first is accepted and then has its edge processed; the
// first corner is only accepted. The last corner also adds the closing edge and
// the result load.
// The edge time is set by the shared 17x17 multiplier (three products) and the
// bit-per-cycle square root (17 steps). s_tready is high only while idle.
// rst synchronously clears the sequencer, the sums and the output valid flag.
// A finished result waits in the output register; a further polygon is held
// at its result load until that register is free.
// ----------------------------------------------------------------------------
module polygon_area_perimeter
  import pap_pkg::*;
#(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // x_coord[15:0], y_coord[31:16]
  input  wire logic             s_tlast,   // last_corner
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // area, perimeter, corner_count, zero pad
  output logic                  m_tuser    // too_many
);

  localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_CORNERS);
  localparam logic [4:0] ROOT_LAST = 5'(ROOT_W - 1);

  state_t state;

  logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [SUM_W-1:0]   twice_area_sum;
  logic [PERIM_W-1:0]        edge_sum;
  logic [COUNT_W-1:0]        corners_seen;
  logic                      overflowed;
  logic                      close_pend, closing;

  logic signed [DIFF_W-1:0]  dx, dy, sy;
  logic signed [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]           sq;
  logic [REM_W-1:0]          rem;
  logic [ROOT_W-1:0]         root;
  logic [4:0]                iter;

  logic                      in_acc;
  logic signed [COORD_W-1:0] x_in, y_in;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SUM_W:0]     area_add;
  logic signed [SUM_W-1:0]   area_sat;
  logic [PERIM_W:0]          edge_add;
  logic [REM_W+1:0]          rem_sh, trial;
  logic [SUM_W-1:0]          area_mag;
  logic [AREA_W-1:0]         area_out;
  logic [PERIM_W-1:0]        perim_out;
  logic                      out_free;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign x_in     = s_tdata[15:0];
  assign y_in     = s_tdata[31:16];
  assign out_free = ~m_tvalid | m_tready;

  // shared multiplier: trapezoid term, then the two squares
  always_comb begin
    case (state)
      S_MUL_A: begin mul_a = dx; mul_b = sy; end
      S_MUL_X: begin mul_a = dx; mul_b = dx; end
      default: begin mul_a = dy; mul_b = dy; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    area_add = {twice_area_sum[SUM_W-1], twice_area_sum} + (SUM_W+1)'(prod);
    if (area_add[SUM_W] != area_add[SUM_W-1])
      area_sat = area_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      area_sat = area_add[SUM_W-1:0];
    edge_add = {1'b0, edge_sum} + (PERIM_W+1)'(root);
    rem_sh   = {rem, sq[SQ_W-1 -: 2]};
    trial    = {1'b0, root, 2'b01};
    area_mag = twice_area_sum[SUM_W-1] ? SUM_W'(-twice_area_sum) : twice_area_sum;
    if (overflowed) begin
      area_out  = AREA_CAP;
      perim_out = PERIM_CAP;
    end else begin
      area_out  = (area_mag > SUM_W'(AREA_CAP)) ? AREA_CAP : area_mag[AREA_W-1:0];
      perim_out = edge_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      first_x        <= '0;
      first_y        <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      twice_area_sum <= '0;
      edge_sum       <= '0;
      corners_seen   <= '0;
      overflowed     <= 1'b0;
      close_pend     <= 1'b0;
      closing        <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE)
        m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            close_pend <= s_tlast;
            closing    <= 1'b0;
            prev_x     <= x_in;
            prev_y     <= y_in;
            if (corners_seen >= MAX_C || corners_seen >= COUNT_CAP)
              overflowed <= 1'b1;
            if (corners_seen < COUNT_CAP)
              corners_seen <= corners_seen + 1'b1;
            if (corners_seen == '0) begin
              first_x <= x_in;
              first_y <= y_in;
              state   <= s_tlast ? S_CLOSE : S_IDLE;
            end else begin
              dx    <= {x_in[15], x_in} - {prev_x[15], prev_x};
              dy    <= {y_in[15], y_in} - {prev_y[15], prev_y};
              sy    <= {y_in[15], y_in} + {prev_y[15], prev_y};
              state <= S_MUL_A;
            end
          end
        end
        S_CLOSE: begin
          // closing edge runs from the last corner back to the first
          dx      <= {first_x[15], first_x} - {prev_x[15], prev_x};
          dy      <= {first_y[15], first_y} - {prev_y[15], prev_y};
          sy      <= {first_y[15], first_y} + {prev_y[15], prev_y};
          closing <= 1'b1;
          state   <= S_MUL_A;
        end
        S_MUL_A: begin
          prod  <= mul_p;
          state <= S_MUL_X;
        end
        S_MUL_X: begin
          twice_area_sum <= area_sat;
          prod           <= mul_p;
          state          <= S_MUL_Y;
        end
        S_MUL_Y: begin
          sq    <= {1'b0, prod[SQ_W-2:0]};
          prod  <= mul_p;
          state <= S_ROOT_LD;
        end
        S_ROOT_LD: begin
          sq    <= sq + {1'b0, prod[SQ_W-2:0]};
          rem   <= '0;
          root  <= '0;
          iter  <= ROOT_LAST;
          state <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle, two radicand bits shifted in
          if (rem_sh >= trial) begin
            rem  <= REM_W'(rem_sh - trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh[REM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          sq   <= {sq[SQ_W-3:0], 2'b00};
          iter <= iter - 1'b1;
          if (iter == '0)
            state <= S_ACC;
        end
        S_ACC: begin
          edge_sum <= edge_add[PERIM_W] ? PERIM_CAP : edge_add[PERIM_W-1:0];
          if (closing)
            state <= S_DONE;
          else if (close_pend)
            state <= S_CLOSE;
          else
            state <= S_IDLE;
        end
        S_DONE: begin
          // hold until the output register is free, then clear for the next polygon
          if (out_free) begin
            m_tvalid       <= 1'b1;
            m_tdata        <= {6'b0, corners_seen, perim_out, area_out};
            m_tuser        <= overflowed;
            first_x        <= '0;
            first_y        <= '0;
            prev_x         <= '0;
            prev_y         <= '0;
            twice_area_sum <= '0;
            edge_sum       <= '0;
            corners_seen   <= '0;
            overflowed     <= 1'b0;
            close_pend     <= 1'b0;
            closing        <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
